// ===== hdl/mmh_pkg.sv =====
`default_nettype none

package mmh_pkg;

    localparam int WordW  = 64;
    localparam int CountW = 5;
    localparam int BlockBytes = 16;

    localparam logic [WordW-1:0] MixC1 = 64'h87c37b91114253d5;
    localparam logic [WordW-1:0] MixC2 = 64'h4cf5ad432745937f;
    localparam logic [WordW-1:0] AddA1 = 64'h0000000052dce729;
    localparam logic [WordW-1:0] AddA2 = 64'h0000000038495ab5;
    localparam logic [WordW-1:0] FinF1 = 64'hff51afd7ed558ccd;
    localparam logic [WordW-1:0] FinF2 = 64'hc4ceb9fe1a85ec53;

    typedef enum logic [3:0] {
        W_HOLD,
        W_K1,
        W_K2,
        W_MUL,
        W_ROT31,
        W_ROT33,
        W_XS,
        W_L1XS,
        W_L2XS
    } w_op_t;

    typedef enum logic [2:0] {
        LN_HOLD,
        LN_MIX,
        LN_MUL5,
        LN_TOT,
        LN_ADD,
        LN_XS,
        LN_SEED
    } lane_op_t;

    typedef enum logic [1:0] {
        K_C1,
        K_C2,
        K_F1,
        K_F2
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        w_op_t    w_op;
        lane_op_t l1_op;
        lane_op_t l2_op;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic use_lo;
        logic use_hi;
        logic full;
        logic last;
        logic mul_busy;
        logic mul_done;
        logic out_free;
    } sts_t;

    // byte i of the lane is kept while the count exceeds its message position
    function automatic logic [WordW-1:0] byte_mask(input logic [CountW-1:0] n,
                                                   input logic hi_half);
        logic [WordW-1:0]  m;
        logic [CountW-1:0] pos;
        m = '0;
        for (int i = 0; i < WordW / 8; i++)
        begin
            pos = CountW'(i) + (hi_half ? CountW'(WordW / 8) : CountW'(0));
            m[8*i +: 8] = {8{n > pos}};
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mmh_mul.sv =====
`default_nettype none

module mmh_mul (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             busy,
    output logic             done,
    output logic [63:0]      product
);
    import mmh_pkg::*;

    typedef enum logic [1:0] {
        PH_LL,
        PH_LH,
        PH_HL
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WordW-1:0] a_reg, b_reg, acc_reg, acc_next;
    logic [31:0]      op_a, op_b;
    logic [WordW-1:0] part;

    always_comb
    begin
        case (phase_reg)
            PH_LL:
            begin
                op_a = a_reg[31:0];
                op_b = b_reg[31:0];
            end
            PH_LH:
            begin
                op_a = a_reg[31:0];
                op_b = b_reg[63:32];
            end
            PH_HL:
            begin
                op_a = a_reg[63:32];
                op_b = b_reg[31:0];
            end
            default:
            begin
                op_a = a_reg[31:0];
                op_b = b_reg[31:0];
            end
        endcase
        part = op_a * op_b;
        if (phase_reg == PH_LL)
            acc_next = part;
        else
            acc_next = acc_reg + {part[31:0], 32'd0};
    end

    always_comb
    begin
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            phase_next = PH_LL;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            case (phase_reg)
                PH_LL: phase_next = PH_LH;
                PH_LH: phase_next = PH_HL;
                PH_HL:
                begin
                    phase_next = PH_LL;
                    busy_next  = 1'b0;
                    done_next  = 1'b1;
                end
                default: phase_next = PH_LL;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LL;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        if (busy_reg)
            acc_reg <= acc_next;
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// ===== hdl/mmh_datapath.sv =====
`default_nettype none

module mmh_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mmh_pkg::cmd_t cmd,
    output mmh_pkg::sts_t      sts,
    input  wire logic [135:0]  s_tdata,
    input  wire logic          s_tlast,
    input  wire logic          seed_we,
    input  wire logic [63:0]   seed_wdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [127:0]       m_tdata
);
    import mmh_pkg::*;

    logic [WordW-1:0]  seed_reg;
    logic [WordW-1:0]  lane1_reg, lane1_next;
    logic [WordW-1:0]  lane2_reg, lane2_next;
    logic [WordW-1:0]  total_reg, total_next;
    logic [WordW-1:0]  w_reg, w_next;
    logic [WordW-1:0]  k1_reg, k2_reg;
    logic              use_lo_reg, use_hi_reg, full_reg, last_reg;
    logic [WordW-1:0]  out_low_reg, out_high_reg;
    logic              out_valid_reg, out_valid_next;
    logic [CountW-1:0] cnt_in, eff_cnt;
    logic [WordW-1:0]  x1, x2, mul_b, mul_p;
    logic              mul_busy, mul_done;

    function automatic logic [WordW-1:0] xs33(input logic [WordW-1:0] v);
        return v ^ {33'd0, v[63:33]};
    endfunction

    assign cnt_in = s_tdata[132:128];

    always_comb
    begin
        if (!s_tlast)
            eff_cnt = CountW'(BlockBytes);
        else if (cnt_in > CountW'(BlockBytes))
            eff_cnt = CountW'(BlockBytes);
        else
            eff_cnt = cnt_in;
    end

    always_comb
    begin
        case (cmd.mul_sel)
            K_C1:    mul_b = MixC1;
            K_C2:    mul_b = MixC2;
            K_F1:    mul_b = FinF1;
            K_F2:    mul_b = FinF2;
            default: mul_b = MixC1;
        endcase
    end

    mmh_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (w_reg),
        .b       (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_p)
    );

    always_comb
    begin
        case (cmd.w_op)
            W_HOLD:  w_next = w_reg;
            W_K1:    w_next = k1_reg;
            W_K2:    w_next = k2_reg;
            W_MUL:   w_next = mul_p;
            W_ROT31: w_next = {w_reg[32:0], w_reg[63:33]};
            W_ROT33: w_next = {w_reg[30:0], w_reg[63:31]};
            W_XS:    w_next = xs33(w_reg);
            W_L1XS:  w_next = xs33(lane1_reg);
            W_L2XS:  w_next = xs33(lane2_reg);
            default: w_next = w_reg;
        endcase
    end

    assign x1 = lane1_reg ^ w_reg;
    assign x2 = lane2_reg ^ w_reg;

    always_comb
    begin
        case (cmd.l1_op)
            LN_HOLD: lane1_next = lane1_reg;
            LN_MIX:  lane1_next = full_reg ? ({x1[36:0], x1[63:37]} + lane2_reg) : x1;
            LN_MUL5: lane1_next = {lane1_reg[61:0], 2'b00} + lane1_reg + AddA1;
            LN_TOT:  lane1_next = lane1_reg ^ total_reg;
            LN_ADD:  lane1_next = lane1_reg + lane2_reg;
            LN_XS:   lane1_next = xs33(w_reg);
            LN_SEED: lane1_next = seed_reg;
            default: lane1_next = lane1_reg;
        endcase
        case (cmd.l2_op)
            LN_HOLD: lane2_next = lane2_reg;
            LN_MIX:  lane2_next = full_reg ? ({x2[32:0], x2[63:33]} + lane1_reg) : x2;
            LN_MUL5: lane2_next = {lane2_reg[61:0], 2'b00} + lane2_reg + AddA2;
            LN_TOT:  lane2_next = lane2_reg ^ total_reg;
            LN_ADD:  lane2_next = lane2_reg + lane1_reg;
            LN_XS:   lane2_next = xs33(w_reg);
            LN_SEED: lane2_next = seed_reg;
            default: lane2_next = lane2_reg;
        endcase
    end

    always_comb
    begin
        total_next = total_reg;
        if (cmd.load)
            total_next = total_reg + {{(WordW-CountW){1'b0}}, eff_cnt};
        else if (cmd.out_load)
            total_next = '0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            lane1_reg     <= '0;
            lane2_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            use_lo_reg    <= 1'b0;
            use_hi_reg    <= 1'b0;
            full_reg      <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (seed_we)
                seed_reg <= seed_wdata;
            lane1_reg     <= lane1_next;
            lane2_reg     <= lane2_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (cmd.load)
            begin
                use_lo_reg <= eff_cnt != '0;
                use_hi_reg <= eff_cnt > CountW'(BlockBytes / 2);
                full_reg   <= eff_cnt == CountW'(BlockBytes);
                last_reg   <= s_tlast;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        if (cmd.load)
        begin
            k1_reg <= s_tdata[63:0] & byte_mask(eff_cnt, 1'b0);
            k2_reg <= s_tdata[127:64] & byte_mask(eff_cnt, 1'b1);
        end
        if (cmd.out_load)
        begin
            out_low_reg  <= lane1_reg;
            out_high_reg <= lane2_reg + lane1_reg;
        end
    end

    assign sts.use_lo   = use_lo_reg;
    assign sts.use_hi   = use_hi_reg;
    assign sts.full     = full_reg;
    assign sts.last     = last_reg;
    assign sts.mul_busy = mul_busy;
    assign sts.mul_done = mul_done;
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_high_reg, out_low_reg};

endmodule

`default_nettype wire

// ===== hdl/mmh_ctrl.sv =====
`default_nettype none

module mmh_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire mmh_pkg::sts_t sts,
    output mmh_pkg::cmd_t      cmd
);
    import mmh_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MWAIT,
        S_L1_LOAD,
        S_L1_M1,
        S_L1_R31,
        S_L1_M2,
        S_L1_MIX,
        S_L1_ADD,
        S_L2_LOAD,
        S_L2_M1,
        S_L2_R33,
        S_L2_M2,
        S_L2_MIX,
        S_L2_ADD,
        S_F_XOR,
        S_F_ADD1,
        S_F_ADD2,
        S_F1_LOAD,
        S_F1_M1,
        S_F1_X2,
        S_F1_M2,
        S_F1_ST,
        S_F2_LOAD,
        S_F2_M1,
        S_F2_X2,
        S_F2_M2,
        S_F2_ST,
        S_G_ADD,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    state_t after_l2;

    assign after_l2 = sts.last ? S_F_XOR : S_IDLE;
    assign s_tready = state_reg == S_IDLE;

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        cmd.load      = 1'b0;
        cmd.w_op      = W_HOLD;
        cmd.l1_op     = LN_HOLD;
        cmd.l2_op     = LN_HOLD;
        cmd.mul_start = 1'b0;
        cmd.mul_sel   = K_C1;
        cmd.out_load  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_L1_LOAD;
                end
            end
            S_MWAIT:
            begin
                if (sts.mul_done)
                begin
                    cmd.w_op   = W_MUL;
                    state_next = ret_reg;
                end
            end
            S_L1_LOAD:
            begin
                if (sts.use_lo)
                begin
                    cmd.w_op   = W_K1;
                    state_next = S_L1_M1;
                end
                else
                    state_next = S_L2_LOAD;
            end
            S_L1_M1:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = K_C1;
                ret_next      = S_L1_R31;
                state_next    = S_MWAIT;
            end
            S_L1_R31:
            begin
                cmd.w_op   = W_ROT31;
                state_next = S_L1_M2;
            end
            S_L1_M2:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = K_C2;
                ret_next      = S_L1_MIX;
                state_next    = S_MWAIT;
            end
            S_L1_MIX:
            begin
                cmd.l1_op  = LN_MIX;
                state_next = sts.full ? S_L1_ADD : S_L2_LOAD;
            end
            S_L1_ADD:
            begin
                cmd.l1_op  = LN_MUL5;
                state_next = S_L2_LOAD;
            end
            S_L2_LOAD:
            begin
                if (sts.use_hi)
                begin
                    cmd.w_op   = W_K2;
                    state_next = S_L2_M1;
                end
                else
                    state_next = after_l2;
            end
            S_L2_M1:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = K_C2;
                ret_next      = S_L2_R33;
                state_next    = S_MWAIT;
            end
            S_L2_R33:
            begin
                cmd.w_op   = W_ROT33;
                state_next = S_L2_M2;
            end
            S_L2_M2:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = K_C1;
                ret_next      = S_L2_MIX;
                state_next    = S_MWAIT;
            end
            S_L2_MIX:
            begin
                cmd.l2_op  = LN_MIX;
                state_next = sts.full ? S_L2_ADD : after_l2;
            end
            S_L2_ADD:
            begin
                cmd.l2_op  = LN_MUL5;
                state_next = after_l2;
            end
            S_F_XOR:
            begin
                cmd.l1_op  = LN_TOT;
                cmd.l2_op  = LN_TOT;
                state_next = S_F_ADD1;
            end
            S_F_ADD1:
            begin
                cmd.l1_op  = LN_ADD;
                state_next = S_F_ADD2;
            end
            S_F_ADD2:
            begin
                cmd.l2_op  = LN_ADD;
                state_next = S_F1_LOAD;
            end
            S_F1_LOAD:
            begin
                cmd.w_op   = W_L1XS;
                state_next = S_F1_M1;
            end
            S_F1_M1:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = K_F1;
                ret_next      = S_F1_X2;
                state_next    = S_MWAIT;
            end
            S_F1_X2:
            begin
                cmd.w_op   = W_XS;
                state_next = S_F1_M2;
            end
            S_F1_M2:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = K_F2;
                ret_next      = S_F1_ST;
                state_next    = S_MWAIT;
            end
            S_F1_ST:
            begin
                cmd.l1_op  = LN_XS;
                state_next = S_F2_LOAD;
            end
            S_F2_LOAD:
            begin
                cmd.w_op   = W_L2XS;
                state_next = S_F2_M1;
            end
            S_F2_M1:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = K_F1;
                ret_next      = S_F2_X2;
                state_next    = S_MWAIT;
            end
            S_F2_X2:
            begin
                cmd.w_op   = W_XS;
                state_next = S_F2_M2;
            end
            S_F2_M2:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = K_F2;
                ret_next      = S_F2_ST;
                state_next    = S_MWAIT;
            end
            S_F2_ST:
            begin
                cmd.l2_op  = LN_XS;
                state_next = S_G_ADD;
            end
            S_G_ADD:
            begin
                cmd.l1_op  = LN_ADD;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.l1_op    = LN_SEED;
                    cmd.l2_op    = LN_SEED;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_mul_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |-> !sts.mul_busy)
        else $error("multiply started while busy");

    a_mwait_return: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MWAIT && sts.mul_done) |=> state_reg == $past(ret_reg))
        else $error("multiply wait did not return to caller");

    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result overwritten before taken");

    a_done_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |=> ##3 sts.mul_done)
        else $error("multiply latency broken");
`endif

endmodule

`default_nettype wire

// ===== hdl/murmur3_128_hash.sv =====
// Channel    Dir  Handshake          Payload
// s_*        in   s_tvalid/s_tready  s_tdata: block_low, block_high, byte_count; s_tlast: last
// m_*        out  m_tvalid/m_tready  m_tdata: hash_low, hash_high
// seed_*     in   seed_we            seed_wdata: seed
//
// A block is taken only in the idle state, so a new block waits until the previous
// block, and any digest behind it, is through.
// All multiplies share one 32x32 multiplier, which forms a 64-bit product from
// its low-low, low-high and high-low partial products.
// Reset clears the lanes, the byte count and the seed to zero.
// A finished digest waits in the output register; a stalled m_tready holds the
// next digest back only when another one is ready to be written there.
`default_nettype none

module murmur3_128_hash (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [135:0] s_tdata,   // block_low, block_high, byte_count, zero pad
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // hash_low, hash_high
    input  wire logic         seed_we,
    input  wire logic [63:0]  seed_wdata
);
    import mmh_pkg::*;

    cmd_t cmd;
    sts_t sts;

    mmh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mmh_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .seed_we    (seed_we),
        .seed_wdata (seed_wdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire
